@@ hdl/piecewise_linear_curve_lookup_macros.svh @@
// Assertion macros used by the curve lookup module.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PLCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PLCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plcl_pkg.sv @@
// Types, codes and constants of the piecewise-linear curve lookup.
package plcl_pkg;

  localparam int BpW      = 16;
  localparam int ValueW   = 24;
  localparam int FracW    = 8;
  localparam int EntriesW = 5;
  localparam int SegW     = 4;
  localparam int ProdMagW = 40;
  localparam int DxMagW   = 16;

  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  localparam logic OpQuery = 1'b0;
  localparam logic OpLoad  = 1'b1;

  localparam logic RegMaxCycle = 1'b0;
  localparam logic RegEntries  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [2:0]        curve_select;
    logic [3:0]        entry_index;
    logic [BpW-1:0]    breakpoint_cycles;
    logic [ValueW-1:0] entry_value;
    logic [BpW-1:0]    query_cycles;
    logic              whole_units;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] curve_value;
    logic [SegW-1:0]   segment_index;
    logic              exact_hit;
    logic              saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StFirst,
    StScan,
    StVal0,
    StVal1,
    StVal2,
    StMul,
    StDiv,
    StEmit
  } plcl_state_e;

endpackage

@@ hdl/plcl_stream_if.sv @@
// Valid/ready stream interface that carries one item per handshake.
interface plcl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/plcl_divider.sv @@
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module plcl_divider
  import plcl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ProdMagW-1:0] dividend_i,
  input  logic [DxMagW-1:0]   divisor_i,
  output logic [ProdMagW-1:0] quotient_o,
  output logic                done_o
);

  localparam int CntW = $clog2(ProdMagW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DxMagW-1:0]   rem_q, rem_d;
  logic [ProdMagW-1:0] quo_q, quo_d;
  logic [DxMagW-1:0]   den_q, den_d;
  logic [DxMagW:0]     trial;
  logic [DxMagW:0]     diff;
  logic                fits;

  assign trial = {rem_q, quo_q[ProdMagW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(ProdMagW - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DxMagW-1:0] : trial[DxMagW-1:0];
      quo_d = {quo_q[ProdMagW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

@@ hdl/piecewise_linear_curve_lookup.sv @@
// Piecewise-linear curve lookup over loadable breakpoint and value memories.
//
//   channel  direction  handshake               contents
//   in_i     sink       valid/ready             load or query item
//   out_o    source     valid/ready             one result item per input item
//   apb      slave      psel/penable, pready=1  cycle limit, entries in use
//
// A load or a query of a missing curve goes from idle straight to emit; a query
// otherwise reads breakpoint 0 and then runs S (1 to TABLE_ENTRIES - 1) compare
// steps, one per cycle. A hit or zero-width segment then emits; an interpolation
// multiplies and runs the 40-step serial divider. The memories need no clearing
// after reset if entries are written before being read; this is not enforced.
// A finished result waits in the output register while the next item is taken in.

`include "piecewise_linear_curve_lookup_macros.svh"

module piecewise_linear_curve_lookup
  import plcl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int CURVE_COUNT   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plcl_stream_if.sink   in_i,
  plcl_stream_if.source out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IdxW     = $clog2(TABLE_ENTRIES);
  localparam int ValDepth = CURVE_COUNT * TABLE_ENTRIES;
  localparam int VaW      = $clog2(ValDepth);
  localparam int CntW     = ($clog2(TABLE_ENTRIES + 1) > EntriesW) ?
                            $clog2(TABLE_ENTRIES + 1) : EntriesW;

  // Configuration registers.
  logic [BpW-1:0]      max_cycle_q;
  logic [EntriesW-1:0] entries_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cycle_q <= {BpW{1'b1}};
      entries_q   <= EntriesW'(16);
    end else if (cfg_we) begin
      case (paddr[2])
        RegMaxCycle: max_cycle_q <= pwdata[BpW-1:0];
        RegEntries:  entries_q   <= pwdata[EntriesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegMaxCycle: prdata = 32'(max_cycle_q);
      RegEntries:  prdata = 32'(entries_q);
      default:     prdata = '0;
    endcase
  end

  // Memories.
  logic [BpW-1:0]    bp_mem [TABLE_ENTRIES];
  logic [ValueW-1:0] val_mem [ValDepth];
  logic              bp_we, bp_re, val_we, val_re;
  logic [IdxW-1:0]   bp_waddr, bp_raddr;
  logic [VaW-1:0]    val_waddr, val_raddr;
  logic [BpW-1:0]    bp_rdata_q;
  logic [ValueW-1:0] val_rdata_q;

  always_ff @(posedge clk_i) begin
    if (bp_we) begin
      bp_mem[bp_waddr] <= in_i.payload.breakpoint_cycles;
    end
    if (bp_re) begin
      bp_rdata_q <= bp_mem[bp_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= in_i.payload.entry_value;
    end
    if (val_re) begin
      val_rdata_q <= val_mem[val_raddr];
    end
  end

  // Sequencer state and working registers.
  plcl_state_e         state_q, state_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [BpW-1:0]      cyc_q, cyc_d;
  logic                whole_q, whole_d;
  logic [VaW-1:0]      base_q, base_d;
  logic [IdxW-1:0]     n_last_q, n_last_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [BpW-1:0]      prev_q, prev_d;
  logic                hit_q, hit_d;
  logic signed [16:0]  dx_q, dx_d;
  logic signed [16:0]  dc_q, dc_d;
  logic [ValueW-1:0]   y0_q, y0_d;
  logic signed [41:0]  prod_q, prod_d;
  logic                neg_q, neg_d;
  logic [ValueW-1:0]   res_value_q, res_value_d;
  logic                res_hit_q, res_hit_d;
  logic                res_sat_q, res_sat_d;

  logic                in_acc, is_load, load_ok, curve_ok, out_free;
  logic [BpW-1:0]      cyc_clamped;
  logic [CntW-1:0]     ent_ext, n_used;
  logic [IdxW-1:0]     idx_next;
  logic                bp_lt;
  logic signed [24:0]  dy;
  logic signed [41:0]  prod_abs;
  logic signed [16:0]  dx_abs;
  logic                div_start, div_done;
  logic [ProdMagW-1:0] div_quo;
  logic signed [42:0]  q_ext, q_signed, y_sum;
  logic [ValueW-1:0]   frac_mask;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = (in_i.payload.operation == OpLoad);
  assign curve_ok   = int'(in_i.payload.curve_select) < CURVE_COUNT;
  assign load_ok    = curve_ok && (int'(in_i.payload.entry_index) < TABLE_ENTRIES);
  assign out_free   = !out_valid_q || out_o.ready;

  assign cyc_clamped = (in_i.payload.query_cycles > max_cycle_q) ?
                       max_cycle_q : in_i.payload.query_cycles;

  always_comb begin
    ent_ext = CntW'(entries_q);
    if (ent_ext < CntW'(2)) begin
      n_used = CntW'(2);
    end else if (ent_ext > CntW'(TABLE_ENTRIES)) begin
      n_used = CntW'(TABLE_ENTRIES);
    end else begin
      n_used = ent_ext;
    end
  end

  assign idx_next  = idx_q + IdxW'(1);
  assign bp_lt     = bp_rdata_q < cyc_q;
  assign dy        = $signed({1'b0, val_rdata_q}) - $signed({1'b0, y0_q});
  assign prod_abs  = prod_q[41] ? -prod_q : prod_q;
  assign dx_abs    = dx_q[16] ? -dx_q : dx_q;
  assign q_ext     = $signed({3'b000, div_quo});
  assign q_signed  = neg_q ? -q_ext : q_ext;
  assign y_sum     = $signed({19'd0, y0_q}) + q_signed;
  assign frac_mask = {{(ValueW - FracW){1'b1}}, {FracW{~whole_q}}};

  assign bp_we     = in_acc && is_load && load_ok;
  assign bp_waddr  = IdxW'(in_i.payload.entry_index);
  assign val_we    = bp_we;
  assign val_waddr = VaW'(int'(in_i.payload.curve_select) * TABLE_ENTRIES
                          + int'(in_i.payload.entry_index));

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    cyc_d       = cyc_q;
    whole_d     = whole_q;
    base_d      = base_q;
    n_last_d    = n_last_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    dx_d        = dx_q;
    dc_d        = dc_q;
    y0_d        = y0_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_value_d = res_value_q;
    res_hit_d   = res_hit_q;
    res_sat_d   = res_sat_q;
    bp_re       = 1'b0;
    bp_raddr    = '0;
    val_re      = 1'b0;
    val_raddr   = '0;
    div_start   = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          idx_d       = '0;
          res_value_d = '0;
          res_hit_d   = 1'b0;
          res_sat_d   = 1'b0;
          whole_d     = 1'b0;
          if (is_load || !curve_ok) begin
            state_d = StEmit;
          end else begin
            cyc_d    = cyc_clamped;
            whole_d  = in_i.payload.whole_units;
            base_d   = VaW'(int'(in_i.payload.curve_select) * TABLE_ENTRIES);
            n_last_d = IdxW'(n_used - CntW'(1));
            hit_d    = 1'b0;
            bp_re    = 1'b1;
            bp_raddr = '0;
            state_d  = StFirst;
          end
        end
      end
      StFirst: begin
        prev_d   = bp_rdata_q;
        bp_re    = 1'b1;
        bp_raddr = IdxW'(1);
        state_d  = StScan;
      end
      StScan: begin
        if (bp_lt) begin
          idx_d  = idx_next;
          prev_d = bp_rdata_q;
          if (idx_next == n_last_q) begin
            hit_d   = 1'b1;
            state_d = StVal0;
          end else begin
            bp_re    = 1'b1;
            bp_raddr = idx_q + IdxW'(2);
          end
        end else begin
          hit_d   = (prev_q == cyc_q);
          dx_d    = $signed({1'b0, bp_rdata_q}) - $signed({1'b0, prev_q});
          dc_d    = $signed({1'b0, cyc_q}) - $signed({1'b0, prev_q});
          state_d = StVal0;
        end
      end
      StVal0: begin
        val_re    = 1'b1;
        val_raddr = base_q + VaW'(idx_q);
        state_d   = StVal1;
      end
      StVal1: begin
        y0_d = val_rdata_q;
        if (hit_q || (dx_q == '0)) begin
          res_value_d = val_rdata_q;
          res_hit_d   = hit_q;
          res_sat_d   = 1'b0;
          state_d     = StEmit;
        end else begin
          val_re    = 1'b1;
          val_raddr = base_q + VaW'(idx_q) + VaW'(1);
          state_d   = StVal2;
        end
      end
      StVal2: begin
        prod_d  = dy * dc_q;
        state_d = StMul;
      end
      StMul: begin
        div_start = 1'b1;
        neg_d     = prod_q[41] ^ dx_q[16];
        state_d   = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          res_hit_d = 1'b0;
          if (y_sum[42]) begin
            res_value_d = '0;
            res_sat_d   = 1'b1;
          end else if (y_sum > $signed({19'd0, ValueMax})) begin
            res_value_d = ValueMax;
            res_sat_d   = 1'b1;
          end else begin
            res_value_d = y_sum[ValueW-1:0];
            res_sat_d   = 1'b0;
          end
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.curve_value   = res_value_q & frac_mask;
          out_d.segment_index = SegW'(idx_q);
          out_d.exact_hit     = res_hit_q;
          out_d.saturated     = res_sat_q;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q       <= out_d;
    cyc_q       <= cyc_d;
    whole_q     <= whole_d;
    base_q      <= base_d;
    n_last_q    <= n_last_d;
    idx_q       <= idx_d;
    prev_q      <= prev_d;
    hit_q       <= hit_d;
    dx_q        <= dx_d;
    dc_q        <= dc_d;
    y0_q        <= y0_d;
    prod_q      <= prod_d;
    neg_q       <= neg_d;
    res_value_q <= res_value_d;
    res_hit_q   <= res_hit_d;
    res_sat_q   <= res_sat_d;
  end

  plcl_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_abs[ProdMagW-1:0]),
    .divisor_i  (dx_abs[DxMagW-1:0]),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `PLCL_ASSERT_IMP(a_scan_in_range, state_q == StScan, idx_q < n_last_q, "Scan index passed the last used entry.")
  `PLCL_ASSERT_NXT(a_out_from_emit, !out_valid_q && state_q != StEmit, !out_valid_q, "Result appeared without an emit step.")
  `PLCL_ASSERT_IMP(a_div_done_in_div, div_done, state_q == StDiv, "Divider finished outside the division step.")
  `PLCL_ASSERT_IMP(a_hit_sat_excl, out_valid_q, !(out_q.exact_hit && out_q.saturated), "Exact hit and saturation are both set.")
  `PLCL_ASSERT_NXT(a_load_zero, in_acc && is_load, state_q == StEmit && res_value_q == '0, "Load item left a nonzero result.")

endmodule
